// ===== hdl/tpsdds_pkg.sv =====
package tpsdds_pkg;

  localparam int TABLE_DEPTH        = 256;
  localparam int DEF_PHASE_BITS     = 32;
  localparam int LEVEL_W            = 8;
  localparam int READING_W          = 10;
  localparam int FREQ_W             = 11;
  localparam int DUTY_W             = 7;
  localparam int CFG_ADDR_W         = 3;
  localparam int CFG_DATA_W         = 32;
  localparam int DIV_W              = 21;
  localparam int DIV_CNT_W          = 5;

  localparam logic [7:0]  LOW_RAMP_STEPS   = 8'd19;
  localparam logic [11:0] LOW_STEP_HZ      = 12'd3;
  localparam logic [11:0] HIGH_BASE_HZ     = 12'd60;
  localparam logic [11:0] HIGH_STEP_HZ     = 12'd10;
  localparam logic [10:0] HIGH_ZERO_MIN_HZ = 11'd51;
  localparam logic [10:0] FREQ_LIMIT       = 11'd2047;
  localparam logic [18:0] PCT_RECIP        = 19'd5243;
  localparam int          PCT_SHIFT        = 19;
  localparam logic [12:0] TEN_RECIP        = 13'd6554;
  localparam int          TEN_SHIFT        = 16;

  localparam logic [9:0]  RST_MIN_READING  = 10'd93;
  localparam logic [9:0]  RST_MAX_READING  = 10'd664;
  localparam logic [10:0] RST_FREQ_MIN     = 11'd170;
  localparam logic [10:0] RST_FREQ_MAX     = 11'd1000;
  localparam logic [31:0] RST_TUNING_PER_HZ = 32'd1095208;
  localparam logic [6:0]  RST_DUTY         = 7'd100;
  localparam logic [7:0]  RST_OFFSET_B     = 8'd85;
  localparam logic [7:0]  RST_OFFSET_C     = 8'd170;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_RAMP   = 2'd1,
    OP_SPEED  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    RS_IDLE = 2'd0,
    RS_LOW  = 2'd1,
    RS_HIGH = 2'd2,
    RS_SPARE = 2'd3
  } ramp_stage_t;

  typedef enum logic [2:0] {
    CFG_MIN_READING = 3'd0,
    CFG_MAX_READING = 3'd1,
    CFG_FREQ_MIN    = 3'd2,
    CFG_FREQ_MAX    = 3'd3,
    CFG_TUNING      = 3'd4,
    CFG_DUTY        = 3'd5,
    CFG_OFFSET_B    = 3'd6,
    CFG_OFFSET_C    = 3'd7
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_MAP,
    ST_FIN,
    ST_MUL,
    ST_RD,
    ST_SC1,
    ST_SC2,
    ST_DONE
  } state_t;

  localparam logic [7:0] SINE_ROM [TABLE_DEPTH] = '{
    8'd127,8'd130,8'd133,8'd136,8'd140,8'd143,8'd146,8'd149,8'd152,8'd155,8'd158,8'd161,
    8'd164,8'd167,8'd170,8'd173,8'd176,8'd179,8'd182,8'd185,8'd187,8'd190,8'd193,8'd195,
    8'd198,8'd201,8'd203,8'd206,8'd208,8'd211,8'd213,8'd215,8'd217,8'd220,8'd222,8'd224,
    8'd226,8'd228,8'd230,8'd232,8'd233,8'd235,8'd237,8'd238,8'd240,8'd241,8'd242,8'd244,
    8'd245,8'd246,8'd247,8'd248,8'd249,8'd250,8'd251,8'd252,8'd252,8'd253,8'd253,8'd254,
    8'd254,8'd254,8'd254,8'd255,8'd255,8'd254,8'd254,8'd254,8'd254,8'd253,8'd253,8'd252,
    8'd252,8'd251,8'd250,8'd250,8'd249,8'd248,8'd247,8'd246,8'd244,8'd243,8'd242,8'd240,
    8'd239,8'd237,8'd236,8'd234,8'd232,8'd231,8'd229,8'd227,8'd225,8'd223,8'd221,8'd219,
    8'd216,8'd214,8'd212,8'd209,8'd207,8'd204,8'd202,8'd199,8'd197,8'd194,8'd191,8'd189,
    8'd186,8'd183,8'd180,8'd177,8'd175,8'd172,8'd169,8'd166,8'd163,8'd160,8'd157,8'd154,
    8'd150,8'd147,8'd144,8'd141,8'd138,8'd135,8'd132,8'd129,8'd125,8'd122,8'd119,8'd116,
    8'd113,8'd110,8'd107,8'd104,8'd100,8'd97,8'd94,8'd91,8'd88,8'd85,8'd82,8'd79,
    8'd77,8'd74,8'd71,8'd68,8'd65,8'd63,8'd60,8'd57,8'd55,8'd52,8'd50,8'd47,
    8'd45,8'd42,8'd40,8'd38,8'd35,8'd33,8'd31,8'd29,8'd27,8'd25,8'd23,8'd22,
    8'd20,8'd18,8'd17,8'd15,8'd14,8'd12,8'd11,8'd10,8'd8,8'd7,8'd6,8'd5,
    8'd4,8'd4,8'd3,8'd2,8'd2,8'd1,8'd1,8'd0,8'd0,8'd0,8'd0,8'd0,
    8'd0,8'd0,8'd0,8'd0,8'd0,8'd1,8'd1,8'd2,8'd2,8'd3,8'd4,8'd5,
    8'd6,8'd7,8'd8,8'd9,8'd10,8'd12,8'd13,8'd14,8'd16,8'd17,8'd19,8'd21,
    8'd22,8'd24,8'd26,8'd28,8'd30,8'd32,8'd34,8'd37,8'd39,8'd41,8'd43,8'd46,
    8'd48,8'd51,8'd53,8'd56,8'd59,8'd61,8'd64,8'd67,8'd69,8'd72,8'd75,8'd78,
    8'd81,8'd84,8'd87,8'd90,8'd93,8'd96,8'd99,8'd102,8'd105,8'd108,8'd111,8'd114,
    8'd118,8'd121,8'd124,8'd127
  };

endpackage

// ===== hdl/tpsdds_if.sv =====
interface tpsdds_in_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         operation;
  logic [tpsdds_pkg::READING_W-1:0]   adc_reading;
  modport source (output valid, operation, adc_reading, input ready);
  modport sink (input valid, operation, adc_reading, output ready);
endinterface

interface tpsdds_out_if;
  logic                             valid;
  logic                             ready;
  logic [tpsdds_pkg::LEVEL_W-1:0]   phase_a_level;
  logic [tpsdds_pkg::LEVEL_W-1:0]   phase_b_level;
  logic [tpsdds_pkg::LEVEL_W-1:0]   phase_c_level;
  logic                             drive_enabled;
  logic                             ramp_active;
  logic [tpsdds_pkg::FREQ_W-1:0]    frequency_hz;
  modport source (output valid, phase_a_level, phase_b_level, phase_c_level,
                  drive_enabled, ramp_active, frequency_hz, input ready);
  modport sink (input valid, phase_a_level, phase_b_level, phase_c_level,
                drive_enabled, ramp_active, frequency_hz, output ready);
endinterface

// ===== hdl/three_phase_sine_dds_soft_start_core.sv =====
// A beat is accepted in ST_IDLE and decided in ST_EXEC. A beat that only reports
// status goes straight to ST_DONE; otherwise the three sine table reads run. A ramp
// step that loads a new tuning word first passes ST_MUL; a speed beat that starts
// the drive passes the restoring divider (ST_DIV), ST_MAP, ST_FIN and ST_MUL, and
// skips ST_DIV with a zero input span. One beat at a time; the next beat is taken
// once the result is in the output register. Each sine read passes ST_RD, ST_SC1
// and ST_SC2 on the one table port. A full output register holds the core until taken.
// Reset: synchronous, active low; state and config registers take defaults, drive off.
module three_phase_sine_dds_soft_start_core #(
  parameter int PHASE_BITS = tpsdds_pkg::DEF_PHASE_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  tpsdds_in_if.sink                         in_ch,
  tpsdds_out_if.source                      out_ch,
  input  logic                              cfg_we,
  input  logic [tpsdds_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [tpsdds_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int DIV_W_L     = tpsdds_pkg::DIV_W;
  localparam int DIV_CNT_W_L = tpsdds_pkg::DIV_CNT_W;

  tpsdds_pkg::state_t state_r, state_nxt;

  logic [9:0]  min_reading_r, max_reading_r;
  logic [10:0] freq_min_r, freq_max_r;
  logic [31:0] tuning_per_hz_r;
  logic [6:0]  duty_r;
  logic [7:0]  offset_b_r, offset_c_r;

  logic [PHASE_BITS-1:0] acc_r, tuning_r;
  logic                  motor_on_r;
  logic [9:0]            prev_reading_r;
  logic [10:0]           target_r;
  tpsdds_pkg::ramp_stage_t stage_r;
  logic [7:0]            ridx_r;
  logic [7:0]            fin_r;
  logic                  fin_neg_r;

  logic [1:0]  op_r;
  logic [9:0]  rd_r;

  logic [DIV_W_L-1:0] quo_r;
  logic [9:0]  rem_r, den_r;
  logic [tpsdds_pkg::DIV_CNT_W-1:0] cnt_r;
  logic        qneg_r;

  logic [1:0]  ph_r;
  logic [7:0]  rom_q_r;
  logic [14:0] prod_r;
  logic [7:0]  lvl_a_r, lvl_b_r, lvl_c_r;

  logic        out_valid_r;
  logic [7:0]  out_a_r, out_b_r, out_c_r;
  logic        out_drv_r, out_ramp_r;
  logic [10:0] out_freq_r;

  logic        in_ready;

  // Current frequency from the ramp state.
  logic [11:0] freq_cur;
  always_comb begin
    if (!motor_on_r) begin
      freq_cur = '0;
    end else begin
      unique case (stage_r)
        tpsdds_pkg::RS_LOW:  freq_cur = tpsdds_pkg::LOW_STEP_HZ * {4'd0, ridx_r};
        tpsdds_pkg::RS_HIGH: freq_cur = tpsdds_pkg::HIGH_BASE_HZ +
                                        tpsdds_pkg::HIGH_STEP_HZ * {4'd0, ridx_r};
        default: begin
          if (fin_neg_r) begin
            freq_cur = tpsdds_pkg::LOW_STEP_HZ * {4'd0, tpsdds_pkg::LOW_RAMP_STEPS};
          end else begin
            freq_cur = tpsdds_pkg::HIGH_BASE_HZ +
                       tpsdds_pkg::HIGH_STEP_HZ * {4'd0, fin_r};
          end
        end
      endcase
    end
  end

  // Decisions taken on the beat being executed.
  logic        start_cmd, stop_cmd, ramp_load;
  tpsdds_pkg::ramp_stage_t rs_new;
  logic [7:0]  ri_new;
  logic [10:0] rdiff;
  logic [11:0] dfreq, dfmag;
  logic [10:0] span;
  logic        span_zero;

  always_comb begin
    start_cmd = 1'b0;
    stop_cmd  = 1'b0;
    if (op_r == tpsdds_pkg::OP_SPEED && stage_r == tpsdds_pkg::RS_IDLE &&
        rd_r == prev_reading_r) begin
      if (motor_on_r && rd_r < min_reading_r) begin
        stop_cmd = 1'b1;
      end else if (!motor_on_r && rd_r >= min_reading_r) begin
        start_cmd = 1'b1;
      end
    end
    rs_new = stage_r;
    ri_new = ridx_r;
    unique case (stage_r)
      tpsdds_pkg::RS_LOW: begin
        if (ridx_r < tpsdds_pkg::LOW_RAMP_STEPS) begin
          ri_new = ridx_r + 8'd1;
        end else if (!fin_neg_r) begin
          rs_new = tpsdds_pkg::RS_HIGH;
          ri_new = '0;
        end else begin
          rs_new = tpsdds_pkg::RS_IDLE;
        end
      end
      tpsdds_pkg::RS_HIGH: begin
        if (ridx_r < fin_r) begin
          ri_new = ridx_r + 8'd1;
        end else begin
          rs_new = tpsdds_pkg::RS_IDLE;
        end
      end
      default: ;
    endcase
    ramp_load = op_r == tpsdds_pkg::OP_RAMP && motor_on_r &&
                stage_r != tpsdds_pkg::RS_IDLE && rs_new != tpsdds_pkg::RS_IDLE;
    rdiff = {1'b0, rd_r} - {1'b0, min_reading_r};
    dfreq = {1'b0, freq_max_r} - {1'b0, freq_min_r};
    dfmag = dfreq[11] ? (12'd0 - dfreq) : dfreq;
    span  = {1'b0, max_reading_r} - {1'b0, min_reading_r};
    span_zero = span == '0;
  end

  // Divider step.
  logic [10:0] rem_sh;
  logic        rem_ge;
  always_comb begin
    rem_sh = {rem_r, quo_r[DIV_W_L-1]};
    rem_ge = rem_sh >= {1'b0, den_r};
  end

  // Mapping result and saturation.
  logic signed [22:0] qs, fsum;
  logic [10:0] fsat;
  always_comb begin
    qs   = qneg_r ? (23'sd0 - $signed({2'b00, quo_r})) : $signed({2'b00, quo_r});
    fsum = qs + $signed({12'd0, freq_min_r});
    if (fsum < 0) begin
      fsat = '0;
    end else if (fsum > $signed({12'd0, tpsdds_pkg::FREQ_LIMIT})) begin
      fsat = tpsdds_pkg::FREQ_LIMIT;
    end else begin
      fsat = fsum[10:0];
    end
  end

  logic [10:0] tgt_off;
  logic [23:0] tgt_scaled;
  always_comb begin
    tgt_off    = target_r - tpsdds_pkg::HIGH_BASE_HZ[10:0];
    tgt_scaled = {13'd0, tgt_off} * {11'd0, tpsdds_pkg::TEN_RECIP};
  end

  logic [43:0] tune_prod;
  assign tune_prod = {12'd0, tuning_per_hz_r} * {32'd0, freq_cur};

  logic [7:0] idx, rom_addr;
  assign idx = acc_r[PHASE_BITS-1 -: 8];
  always_comb begin
    unique case (ph_r)
      2'd1:    rom_addr = idx + offset_b_r;
      2'd2:    rom_addr = idx + offset_c_r;
      default: rom_addr = idx;
    endcase
  end

  logic [33:0] scaled;
  logic [8:0]  lvl_q;
  logic [7:0]  lvl_sat;
  always_comb begin
    scaled  = {19'd0, prod_r} * {15'd0, tpsdds_pkg::PCT_RECIP};
    lvl_q   = scaled[tpsdds_pkg::PCT_SHIFT +: 9];
    lvl_sat = lvl_q[8] ? 8'hFF : lvl_q[7:0];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tpsdds_pkg::ST_IDLE: if (in_ch.valid) state_nxt = tpsdds_pkg::ST_EXEC;
      tpsdds_pkg::ST_EXEC: begin
        if (start_cmd) begin
          state_nxt = span_zero ? tpsdds_pkg::ST_MAP : tpsdds_pkg::ST_DIV;
        end else if (ramp_load) begin
          state_nxt = tpsdds_pkg::ST_MUL;
        end else if (motor_on_r && !stop_cmd) begin
          state_nxt = tpsdds_pkg::ST_RD;
        end else begin
          state_nxt = tpsdds_pkg::ST_DONE;
        end
      end
      tpsdds_pkg::ST_DIV: if (cnt_r == DIV_CNT_W_L'(1)) state_nxt = tpsdds_pkg::ST_MAP;
      tpsdds_pkg::ST_MAP: state_nxt = tpsdds_pkg::ST_FIN;
      tpsdds_pkg::ST_FIN: state_nxt = tpsdds_pkg::ST_MUL;
      tpsdds_pkg::ST_MUL: state_nxt = tpsdds_pkg::ST_RD;
      tpsdds_pkg::ST_RD:  state_nxt = tpsdds_pkg::ST_SC1;
      tpsdds_pkg::ST_SC1: state_nxt = tpsdds_pkg::ST_SC2;
      tpsdds_pkg::ST_SC2: state_nxt = (ph_r == 2'd2) ? tpsdds_pkg::ST_DONE
                                                      : tpsdds_pkg::ST_RD;
      tpsdds_pkg::ST_DONE: if (!out_valid_r || out_ch.ready) state_nxt = tpsdds_pkg::ST_IDLE;
      default: state_nxt = tpsdds_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = state_r == tpsdds_pkg::ST_IDLE;
  end

  assign in_ch.ready          = in_ready;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.phase_a_level = out_a_r;
  assign out_ch.phase_b_level = out_b_r;
  assign out_ch.phase_c_level = out_c_r;
  assign out_ch.drive_enabled = out_drv_r;
  assign out_ch.ramp_active   = out_ramp_r;
  assign out_ch.frequency_hz  = out_freq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tpsdds_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rom_q_r <= tpsdds_pkg::SINE_ROM[rom_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_reading_r   <= tpsdds_pkg::RST_MIN_READING;
      max_reading_r   <= tpsdds_pkg::RST_MAX_READING;
      freq_min_r      <= tpsdds_pkg::RST_FREQ_MIN;
      freq_max_r      <= tpsdds_pkg::RST_FREQ_MAX;
      tuning_per_hz_r <= tpsdds_pkg::RST_TUNING_PER_HZ;
      duty_r          <= tpsdds_pkg::RST_DUTY;
      offset_b_r      <= tpsdds_pkg::RST_OFFSET_B;
      offset_c_r      <= tpsdds_pkg::RST_OFFSET_C;
    end else if (cfg_we) begin
      unique case (tpsdds_pkg::cfg_reg_t'(cfg_addr))
        tpsdds_pkg::CFG_MIN_READING: min_reading_r   <= cfg_wdata[9:0];
        tpsdds_pkg::CFG_MAX_READING: max_reading_r   <= cfg_wdata[9:0];
        tpsdds_pkg::CFG_FREQ_MIN:    freq_min_r      <= cfg_wdata[10:0];
        tpsdds_pkg::CFG_FREQ_MAX:    freq_max_r      <= cfg_wdata[10:0];
        tpsdds_pkg::CFG_TUNING:      tuning_per_hz_r <= cfg_wdata;
        tpsdds_pkg::CFG_DUTY:        duty_r          <= cfg_wdata[6:0];
        tpsdds_pkg::CFG_OFFSET_B:    offset_b_r      <= cfg_wdata[7:0];
        default:                     offset_c_r      <= cfg_wdata[7:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r          <= '0;
      tuning_r       <= '0;
      motor_on_r     <= 1'b0;
      prev_reading_r <= '0;
      target_r       <= '0;
      stage_r        <= tpsdds_pkg::RS_IDLE;
      ridx_r         <= '0;
      fin_r          <= '0;
      fin_neg_r      <= 1'b1;
      out_valid_r    <= 1'b0;
    end else begin
      unique case (state_r)
        tpsdds_pkg::ST_IDLE: begin
          op_r <= in_ch.operation;
          rd_r <= in_ch.adc_reading;
        end
        tpsdds_pkg::ST_EXEC: begin
          ph_r <= 2'd0;
          if (op_r == tpsdds_pkg::OP_SAMPLE && motor_on_r) begin
            acc_r <= acc_r + tuning_r;
          end
          if (op_r == tpsdds_pkg::OP_RAMP && motor_on_r) begin
            stage_r <= rs_new;
            ridx_r  <= ri_new;
          end
          if (op_r == tpsdds_pkg::OP_SPEED && stage_r == tpsdds_pkg::RS_IDLE) begin
            prev_reading_r <= rd_r;
          end
          if (stop_cmd) begin
            motor_on_r <= 1'b0;
          end
          if (start_cmd) begin
            motor_on_r <= 1'b1;
            acc_r      <= '0;
            stage_r    <= tpsdds_pkg::RS_LOW;
            ridx_r     <= 8'd1;
            quo_r      <= span_zero ? '0 : rdiff[9:0] * dfmag[10:0];
            rem_r      <= '0;
            den_r      <= span[10] ? (10'd0 - span[9:0]) : span[9:0];
            qneg_r     <= dfreq[11] ^ span[10];
            cnt_r      <= DIV_CNT_W_L'(DIV_W_L);
          end
        end
        tpsdds_pkg::ST_DIV: begin
          cnt_r <= cnt_r - 1'b1;
          if (rem_ge) begin
            rem_r <= 10'(rem_sh - {1'b0, den_r});
            quo_r <= {quo_r[DIV_W_L-2:0], 1'b1};
          end else begin
            rem_r <= rem_sh[9:0];
            quo_r <= {quo_r[DIV_W_L-2:0], 1'b0};
          end
        end
        tpsdds_pkg::ST_MAP: target_r <= fsat;
        tpsdds_pkg::ST_FIN: begin
          if (target_r >= tpsdds_pkg::HIGH_BASE_HZ[10:0]) begin
            fin_r     <= tgt_scaled[tpsdds_pkg::TEN_SHIFT +: 8];
            fin_neg_r <= 1'b0;
          end else begin
            fin_r     <= '0;
            fin_neg_r <= target_r < tpsdds_pkg::HIGH_ZERO_MIN_HZ;
          end
        end
        tpsdds_pkg::ST_MUL: tuning_r <= tune_prod[PHASE_BITS-1:0];
        tpsdds_pkg::ST_RD:  ;
        tpsdds_pkg::ST_SC1: prod_r <= rom_q_r * {1'b0, duty_r};
        tpsdds_pkg::ST_SC2: begin
          ph_r <= ph_r + 2'd1;
          unique case (ph_r)
            2'd0:    lvl_a_r <= lvl_sat;
            2'd1:    lvl_b_r <= lvl_sat;
            default: lvl_c_r <= lvl_sat;
          endcase
        end
        default: ;
      endcase

      if (state_r == tpsdds_pkg::ST_DONE && (!out_valid_r || out_ch.ready)) begin
        out_valid_r <= 1'b1;
        out_a_r     <= motor_on_r ? lvl_a_r : '0;
        out_b_r     <= motor_on_r ? lvl_b_r : '0;
        out_c_r     <= motor_on_r ? lvl_c_r : '0;
        out_drv_r   <= motor_on_r;
        out_ramp_r  <= motor_on_r && stage_r != tpsdds_pkg::RS_IDLE;
        out_freq_r  <= freq_cur[10:0];
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  a_ramp_needs_drive: assert property (@(posedge clk) disable iff (!rst_n)
    stage_r != tpsdds_pkg::RS_IDLE |-> motor_on_r)
    else $error("Ramp running with the drive off.");

  a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == tpsdds_pkg::ST_DIV |=> state_r == tpsdds_pkg::ST_DIV ||
                                      state_r == tpsdds_pkg::ST_MAP)
    else $error("Divider left early.");

  a_low_ramp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stage_r == tpsdds_pkg::RS_LOW |-> ridx_r <= tpsdds_pkg::LOW_RAMP_STEPS)
    else $error("Low ramp index out of range.");

  a_off_beat_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_drv_r |-> out_freq_r == '0 && !out_ramp_r && out_a_r == '0)
    else $error("Beat with the drive off carries nonzero fields.");

endmodule
